// ----- hdl/decimal_seven_segment_formatter_core_defines.svh -----
// ----------------------------------------------------------------------------
// Decimal seven-segment formatter: assertion macros
// Checks are compiled in by default and drop out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_SEVEN_SEGMENT_FORMATTER_CORE_DEFINES_SVH
`define DECIMAL_SEVEN_SEGMENT_FORMATTER_CORE_DEFINES_SVH

`ifndef SYNTH

// Check that a condition implies another one in the same cycle
`define DSSF_ASSERT_SAME(label, clock, resetn, cond, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) \
        (cond) |-> (prop)) else $error(msg);

// Check that a condition implies another one in the next cycle
`define DSSF_ASSERT_NEXT(label, clock, resetn, cond, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) \
        (cond) |=> (prop)) else $error(msg);

`else

`define DSSF_ASSERT_SAME(label, clock, resetn, cond, prop, msg)
`define DSSF_ASSERT_NEXT(label, clock, resetn, cond, prop, msg)

`endif

`endif

// ----- hdl/dssf_pkg.sv -----
// ----------------------------------------------------------------------------
// Decimal seven-segment formatter package
// Widths, digit constants, pipeline record type and segment lookup.
// ----------------------------------------------------------------------------
package dssf_pkg;

    localparam int DIGITS      = 4;
    localparam int MAX_VALUE   = 9999;
    localparam int VALUE_W     = 14;
    localparam int DOTS_W      = 4;
    localparam int COUNT_W     = 3;
    localparam int START_W     = 2;
    localparam int PATTERN_W   = 8;
    localparam int GRID_W      = 3;
    localparam int DIGIT_W     = 4;
    localparam int IDX_W       = $clog2(DIGITS);

    // Record carried through the digit-split pipeline
    typedef struct packed {
        logic [VALUE_W-1:0] num;
        logic [9:0]         rem;
        logic [DIGIT_W-1:0] d_th;
        logic [DIGIT_W-1:0] d_h;
        logic [DIGIT_W-1:0] d_t;
        logic [DOTS_W-1:0]  dots;
        logic [COUNT_W-1:0] count;
        logic [START_W-1:0] start;
    } split_t;

    typedef logic [PATTERN_W-1:0] pattern_t;

    // Map a decimal digit to segments G..A
    function automatic logic [6:0] seg_lookup(input logic [DIGIT_W-1:0] digit);
        logic [6:0] seg;
        case (digit)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

// ----- hdl/dssf_if.sv -----
// ----------------------------------------------------------------------------
// Decimal seven-segment formatter channels
// Valid/ready channels for input items, result beats and configuration.
// ----------------------------------------------------------------------------
interface dssf_in_if;
    logic        valid;
    logic        ready;
    logic [13:0] value;
    logic [3:0]  dot_bits;
    logic [2:0]  digit_count;
    logic [1:0]  start_position;

    modport source (output valid, value, dot_bits, digit_count, start_position,
                    input ready);
    modport sink   (input valid, value, dot_bits, digit_count, start_position,
                    output ready);
endinterface

interface dssf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] segment_pattern;
    logic [2:0] grid_address;
    logic       last_digit;

    modport source (output valid, segment_pattern, grid_address, last_digit,
                    input ready);
    modport sink   (input valid, segment_pattern, grid_address, last_digit,
                    output ready);
endinterface

interface dssf_cfg_if;
    logic valid;
    logic ready;
    logic show_leading_zeros;

    modport source (output valid, show_leading_zeros, input ready);
    modport sink   (input valid, show_leading_zeros, output ready);
endinterface

// ----- hdl/decimal_seven_segment_formatter_core.sv -----
// ----------------------------------------------------------------------------
// Decimal seven-segment formatter core
// Splits a number into four decimal digits, maps them to segment patterns
// and emits the last digit_count patterns with grid addresses.
//
//   Channel  Dir  Payload                                        Beat
//   item     in   value, dot_bits, digit_count, start_position   one number
//   result   out  segment_pattern, grid_address, last_digit      one digit
//   cfg      in   show_leading_zeros                             register write
//
// A number enters every cycle while item is ready; it gives min(digit_count, 4)
// result beats, one per cycle while result is ready, and holds the emitter
// until its last beat goes out. A zero count is dropped on entry, yielding nothing.
// The path from item to first result runs through six split stages,
// the emitter register and the output register.
// Reset clears all valid bits and the leading-zero mode.
// A stall on result backs up through the ready chain; nothing is dropped.
// ----------------------------------------------------------------------------
`include "decimal_seven_segment_formatter_core_defines.svh"

module decimal_seven_segment_formatter_core (
    input  logic        clk,
    input  logic        rst_n,
    dssf_in_if.sink     item,
    dssf_out_if.source  result,
    dssf_cfg_if.sink    cfg
);
    import dssf_pkg::*;

    localparam int NSTAGE = 6;

    localparam logic [VALUE_W-1:0] RECIP_TH = 14'd8389;  // 2^23 / 1000
    localparam logic [15:0]        RECIP_H  = 16'd41;    // 2^12 / 100
    localparam logic [14:0]        RECIP_T  = 15'd205;   // 2^11 / 10

    // Configuration register
    logic slz_reg;

    // Split pipeline
    split_t              stage_reg [NSTAGE];
    split_t              stage_next [NSTAGE];
    logic [NSTAGE-1:0]   stage_valid_reg;
    logic [NSTAGE-1:0]   stage_valid_next;
    logic [NSTAGE-1:0]   stage_adv;

    logic [27:0]         prod_th;
    logic [15:0]         prod_h;
    logic [14:0]         prod_t;
    logic [VALUE_W-1:0]  th_scaled;
    logic [9:0]          h_scaled;
    logic [6:0]          t_scaled;
    logic [DIGIT_W-1:0]  d_ones;

    // Pattern build
    logic [DIGIT_W-1:0]  dec [DIGITS];
    pattern_t            pat [DIGITS];
    logic                leading;

    // Emitter
    pattern_t            em_pat_reg [DIGITS];
    logic [COUNT_W-1:0]  em_cnt_reg;
    logic [START_W-1:0]  em_start_reg;
    logic [IDX_W-1:0]    em_idx_reg;
    logic [IDX_W-1:0]    em_idx_next;
    logic                em_valid_reg;
    logic                em_valid_next;
    logic                em_last;
    logic                em_done;
    logic                em_take;
    logic                em_load;
    logic                em_emit;
    logic [COUNT_W-1:0]  em_sel;

    // Output register
    logic                out_valid_reg;
    logic                out_valid_next;
    pattern_t            out_pat_reg;
    logic [GRID_W-1:0]   out_grid_reg;
    logic                out_last_reg;
    logic                out_can;

    // Take configuration writes at any time
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slz_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            slz_reg <= cfg.show_leading_zeros;
        end
    end

    // Stage arithmetic: reciprocal multiply, then remainder, per decade
    always_comb
    begin
        prod_th   = 28'(stage_reg[0].num) * 28'(RECIP_TH);
        th_scaled = 14'(stage_reg[1].d_th) * 14'd1000;
        prod_h    = 16'(stage_reg[2].rem) * RECIP_H;
        h_scaled  = 10'(stage_reg[3].d_h) * 10'd100;
        prod_t    = 15'(stage_reg[4].rem[6:0]) * RECIP_T;

        // Saturate value and count on entry
        stage_next[0]       = '0;
        stage_next[0].num   = (item.value > 14'(MAX_VALUE)) ? 14'(MAX_VALUE) : item.value;
        stage_next[0].dots  = item.dot_bits;
        stage_next[0].count = (item.digit_count > 3'(DIGITS)) ? 3'(DIGITS)
                                                               : item.digit_count;
        stage_next[0].start = item.start_position;

        stage_next[1]      = stage_reg[0];
        stage_next[1].d_th = prod_th[26:23];

        stage_next[2]      = stage_reg[1];
        stage_next[2].rem  = 10'(stage_reg[1].num - th_scaled);

        stage_next[3]      = stage_reg[2];
        stage_next[3].d_h  = prod_h[15:12];

        stage_next[4]      = stage_reg[3];
        stage_next[4].rem  = stage_reg[3].rem - h_scaled;

        stage_next[5]      = stage_reg[4];
        stage_next[5].d_t  = prod_t[14:11];
    end

    // Backpressure chain, last stage first
    always_comb
    begin
        stage_adv[NSTAGE-1] = !stage_valid_reg[NSTAGE-1] || em_take;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            stage_adv[k] = !stage_valid_reg[k] || stage_adv[k+1];
        end
    end

    assign item.ready = stage_adv[0];

    // Advance valid bits; drop items with a zero count on entry
    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (stage_adv[0])
        begin
            stage_valid_next[0] = item.valid && (item.digit_count != 3'd0);
        end
        for (int k = 1; k < NSTAGE; k++)
        begin
            if (stage_adv[k])
            begin
                stage_valid_next[k] = stage_valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NSTAGE; k++)
        begin
            if (stage_adv[k])
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    // Build patterns: ones digit, leading-zero blanking, dots
    always_comb
    begin
        t_scaled = 7'(stage_reg[5].d_t) * 7'd10;
        d_ones   = 4'(stage_reg[5].rem[6:0] - t_scaled);
        dec[0]   = stage_reg[5].d_th;
        dec[1]   = stage_reg[5].d_h;
        dec[2]   = stage_reg[5].d_t;
        dec[3]   = d_ones;
        leading  = 1'b1;
        for (int k = 0; k < DIGITS; k++)
        begin
            if (dec[k] != 4'd0)
            begin
                pat[k]  = {1'b0, seg_lookup(dec[k])};
                leading = 1'b0;
            end
            else if (slz_reg || !leading || (k == DIGITS - 1))
            begin
                pat[k] = {1'b0, seg_lookup(4'd0)};
            end
            else
            begin
                pat[k] = '0;
            end
            pat[k][PATTERN_W-1] = stage_reg[5].dots[DIGITS-1-k];
        end
    end

    // Emitter control
    assign out_can = !out_valid_reg || result.ready;
    assign em_last = ({1'b0, em_idx_reg} == (em_cnt_reg - 3'd1));
    assign em_emit = em_valid_reg && out_can;
    assign em_done = em_emit && em_last;
    assign em_take = !em_valid_reg || em_done;
    assign em_load = stage_valid_reg[NSTAGE-1] && em_take;
    assign em_sel  = 3'(DIGITS) - em_cnt_reg + {1'b0, em_idx_reg};

    always_comb
    begin
        em_valid_next = em_valid_reg;
        em_idx_next   = em_idx_reg;
        if (em_load)
        begin
            em_valid_next = 1'b1;
            em_idx_next   = '0;
        end
        else if (em_done)
        begin
            em_valid_next = 1'b0;
        end
        else if (em_emit)
        begin
            em_idx_next = em_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_valid_reg <= 1'b0;
            em_idx_reg   <= '0;
        end
        else
        begin
            em_valid_reg <= em_valid_next;
            em_idx_reg   <= em_idx_next;
        end
    end

    // Hold the run of patterns being emitted
    always_ff @(posedge clk)
    begin
        if (em_load)
        begin
            for (int k = 0; k < DIGITS; k++)
            begin
                em_pat_reg[k] <= pat[k];
            end
            em_cnt_reg   <= stage_reg[NSTAGE-1].count;
            em_start_reg <= stage_reg[NSTAGE-1].start;
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_can)
        begin
            out_valid_next = em_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (em_emit)
        begin
            out_pat_reg  <= em_pat_reg[em_sel[IDX_W-1:0]];
            out_grid_reg <= {1'b0, em_start_reg} + {1'b0, em_idx_reg};
            out_last_reg <= em_last;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.segment_pattern = out_pat_reg;
    assign result.grid_address    = out_grid_reg;
    assign result.last_digit      = out_last_reg;

    // Checks
    `DSSF_ASSERT_SAME(a_em_count_range, clk, rst_n, em_valid_reg,
        (em_cnt_reg != 3'd0) && (em_cnt_reg <= 3'(DIGITS)), "emitter count out of range")
    `DSSF_ASSERT_SAME(a_em_idx_range, clk, rst_n, em_valid_reg,
        ({1'b0, em_idx_reg} < em_cnt_reg), "emitter index past its count")
    `DSSF_ASSERT_NEXT(a_done_flags_last, clk, rst_n, em_done,
        out_valid_reg && out_last_reg, "final beat of a run not flagged")

endmodule
